>>> rtl/core/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit page allocator package
// Op and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffpa_pkg;

   // request op codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_MARK,
      ST_ABOVE,
      ST_HEAD_WR,
      ST_WALK,
      ST_MERGE_HEAD,
      ST_SCAN,
      ST_TAKE,
      ST_SPLIT,
      ST_DONE
   } ffpa_state_type;

endpackage

>>> rtl/core/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// First-fit page allocator
// Page pool manager: add free region, allocate first fit, free with merging.
// ----------------------------------------------------------------------------
// One request is in flight at a time. The free bit and block length of every
// page sit in a single page memory (one write and one registered read port
// per cycle), and every step of the sequencer is one access to it, so that
// port sets the rate. After reset a clearing pass writes every entry, during
// which req_stall stays high. A bad request or an allocate above the free
// total goes straight to the done state. Add of N pages reads them to
// check that none is free, then writes them. Free does the same, then
// looks at the page above the range and merges with a block starting there;
// then, unless the range starts at page 0, it reads pages on the way down (a
// taken page or the head of the block below ends the walk) and merges into
// that head. Allocate hops (a hop jumps a whole free block or steps over one
// taken page) until the first fitting block, then makes N writes and one
// more if a remainder is split off. The result register lets the next
// request be taken while a response waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_page_allocator
   import ffpa_pkg::*;
#(
   parameter int PAGES = 256
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_page_index,
   input  logic [8:0] req_page_count,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_page_index_res,
   output logic [8:0] rsp_free_count
);

   // AW: page address, LW: length / count (holds PAGES itself),
   // WW: wide enough for the request fields and PAGES.
   localparam int AW = $clog2(PAGES);
   localparam int LW = AW + 1;
   localparam int HW = LW + 1;
   localparam int EW = LW + 1;
   localparam int WW = (LW > 10) ? LW : 10;

   localparam logic [LW-1:0] PAGES_L = LW'(PAGES);
   localparam logic [HW-1:0] PAGES_H = HW'(PAGES);
   localparam logic [WW-1:0] PAGES_W = WW'(PAGES);

   // ----------------------------------------------------------------------
   // Registers
   // ----------------------------------------------------------------------
   ffpa_state_type state_ff, state_in;

   logic [1:0]    op_ff,       op_in;
   logic [AW-1:0] first_ff,    first_in;
   logic [LW-1:0] count_ff,    count_in;
   logic [LW-1:0] cur_ff,      cur_in;      // page under the sequencer
   logic [LW-1:0] left_ff,     left_in;     // pages still to check / write
   logic [LW-1:0] acc_ff,      acc_in;      // length of the block being freed
   logic [LW-1:0] head_len_ff, head_len_in; // length of the chosen block
   logic [AW-1:0] where_ff,    where_in;
   logic [1:0]    status_ff,   status_in;
   logic [LW-1:0] total_ff,    total_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff;
   logic [7:0] rsp_index_ff;
   logic [8:0] rsp_count_ff;

   // page memory: {free, length}
   logic [EW-1:0] page_mem_ff [PAGES];
   logic [EW-1:0] rd_data_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [EW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;

   // ----------------------------------------------------------------------
   // Request decode (used in idle)
   // ----------------------------------------------------------------------
   logic [WW-1:0] in_count_w;
   logic [WW-1:0] in_first_w;
   logic [WW-1:0] total_w;
   logic          in_accept;
   logic          in_bad;
   logic          in_range_bad;
   logic          in_nofit;
   logic          in_alloc;

   assign in_count_w   = WW'(req_page_count);
   assign in_first_w   = WW'(req_page_index);
   assign total_w      = WW'(total_ff);
   assign in_accept    = req_valid && !req_stall;
   assign in_bad       = (req_page_count == 9'd0) || (req_op == OP_RSVD);
   assign in_alloc     = (req_op == OP_ALLOC);
   assign in_range_bad = (in_first_w + in_count_w) > PAGES_W;
   assign in_nofit     = in_count_w > total_w;

   // ----------------------------------------------------------------------
   // Sequencer helpers
   // ----------------------------------------------------------------------
   logic          rd_free;
   logic [LW-1:0] rd_len;
   logic          last_left;
   logic [LW-1:0] first_ext;
   logic [AW-1:0] first_m1;
   logic [LW-1:0] above;
   logic          above_in_pool;
   logic          above_merge;
   logic [HW-1:0] hop;
   logic          hop_end;
   logic          fits;
   logic          rsp_slot_free;

   assign rd_free       = rd_data_ff[LW];
   assign rd_len        = rd_data_ff[LW-1:0];
   assign last_left     = (left_ff == LW'(1));
   assign first_ext     = {1'b0, first_ff};
   assign first_m1      = first_ff - AW'(1);
   assign above         = first_ext + count_ff;
   assign above_in_pool = above < PAGES_L;
   assign above_merge   = rd_free && (rd_len != '0);
   // hop over a whole free block, or one page otherwise
   assign hop           = {1'b0, cur_ff} +
                          ((rd_free && (rd_len != '0)) ? {1'b0, rd_len} : HW'(1));
   assign hop_end       = hop >= PAGES_H;
   assign fits          = rd_free && (rd_len >= count_ff);
   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);

   // ----------------------------------------------------------------------
   // Next state
   // ----------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cur_ff == PAGES_L - LW'(1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (in_bad) state_in = ST_DONE;
               else if (in_alloc) state_in = in_nofit ? ST_DONE : ST_SCAN;
               else state_in = in_range_bad ? ST_DONE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rd_free) state_in = ST_DONE;
            else if (last_left) state_in = ST_MARK;
         end
         ST_MARK: begin
            if (last_left) begin
               if (op_ff == OP_ADD) state_in = ST_DONE;
               else if (above_in_pool) state_in = ST_ABOVE;
               else if (first_ff == '0) state_in = ST_DONE;
               else state_in = ST_WALK;
            end
         end
         ST_ABOVE: begin
            if (above_merge) state_in = ST_HEAD_WR;
            else if (first_ff == '0) state_in = ST_DONE;
            else state_in = ST_WALK;
         end
         ST_HEAD_WR: begin
            state_in = (first_ff == '0) ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            if (!rd_free) state_in = ST_DONE;
            else if (rd_len != '0) state_in = ST_MERGE_HEAD;
            else if (cur_ff == '0) state_in = ST_DONE;
         end
         ST_MERGE_HEAD: state_in = ST_DONE;
         ST_SCAN: begin
            if (fits) state_in = ST_TAKE;
            else if (hop_end) state_in = ST_DONE;
         end
         ST_TAKE: begin
            if (last_left) state_in = (head_len_ff > count_ff) ? ST_SPLIT : ST_DONE;
         end
         ST_SPLIT: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ----------------------------------------------------------------------
   // Page memory control
   // ----------------------------------------------------------------------
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_ff[AW-1:0];
      mem_wdata = '0;
      mem_raddr = cur_ff[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            mem_raddr = in_alloc ? '0 : in_first_w[AW-1:0];
         end
         ST_CHECK: begin
            mem_raddr = cur_ff[AW-1:0] + AW'(1);
         end
         ST_MARK: begin
            // head page carries the length, the rest are cleared
            mem_we    = 1'b1;
            mem_wdata = {1'b1, (left_ff == count_ff) ? count_ff : LW'(0)};
            mem_raddr = above_in_pool ? above[AW-1:0] : first_m1;
         end
         ST_ABOVE: begin
            mem_we    = above_merge;
            mem_waddr = above[AW-1:0];
            mem_wdata = {1'b1, LW'(0)};
            mem_raddr = first_m1;
         end
         ST_HEAD_WR: begin
            mem_we    = 1'b1;
            mem_waddr = first_ff;
            mem_wdata = {1'b1, acc_ff};
            mem_raddr = first_m1;
         end
         ST_WALK: begin
            mem_we    = rd_free && (rd_len != '0);
            mem_wdata = {1'b1, rd_len + acc_ff};
            mem_raddr = cur_ff[AW-1:0] - AW'(1);
         end
         ST_MERGE_HEAD: begin
            mem_we    = 1'b1;
            mem_waddr = first_ff;
            mem_wdata = {1'b1, LW'(0)};
         end
         ST_SCAN: begin
            mem_raddr = hop[AW-1:0];
         end
         ST_TAKE: begin
            mem_we = 1'b1;
         end
         ST_SPLIT: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, head_len_ff - count_ff};
         end
         ST_DONE: begin
            mem_we = 1'b0;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // ----------------------------------------------------------------------
   // Datapath next values
   // ----------------------------------------------------------------------
   always_comb begin
      op_in       = op_ff;
      first_in    = first_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      left_in     = left_ff;
      acc_in      = acc_ff;
      head_len_in = head_len_ff;
      where_in    = where_ff;
      status_in   = status_ff;
      total_in    = total_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cur_in = cur_ff + LW'(1);
         end
         ST_IDLE: begin
            op_in    = req_op;
            first_in = in_first_w[AW-1:0];
            count_in = in_count_w[LW-1:0];
            left_in  = in_count_w[LW-1:0];
            cur_in   = in_alloc ? LW'(0) : in_first_w[LW-1:0];
            if (in_bad) status_in = STATUS_BAD;
            else if (in_alloc) status_in = in_nofit ? STATUS_NOFIT : STATUS_OK;
            else status_in = in_range_bad ? STATUS_BAD : STATUS_OK;
         end
         ST_CHECK: begin
            if (rd_free) begin
               status_in = STATUS_BAD;          // page already free
            end else if (last_left) begin
               cur_in  = first_ext;
               left_in = count_ff;
            end else begin
               cur_in  = cur_ff + LW'(1);
               left_in = left_ff - LW'(1);
            end
         end
         ST_MARK: begin
            if (last_left) begin
               total_in = total_ff + count_ff;
               acc_in   = count_ff;
               cur_in   = first_ext - LW'(1);
            end else begin
               cur_in  = cur_ff + LW'(1);
               left_in = left_ff - LW'(1);
            end
         end
         ST_ABOVE: begin
            if (above_merge) acc_in = acc_ff + rd_len;
         end
         ST_HEAD_WR: begin
            acc_in = acc_ff;
         end
         ST_WALK: begin
            cur_in = cur_ff - LW'(1);
         end
         ST_MERGE_HEAD: begin
            acc_in = acc_ff;
         end
         ST_SCAN: begin
            if (fits) begin
               where_in    = cur_ff[AW-1:0];
               head_len_in = rd_len;
               left_in     = count_ff;
            end else begin
               cur_in = hop[LW-1:0];
               if (hop_end) status_in = STATUS_NOFIT;
            end
         end
         ST_TAKE: begin
            cur_in  = cur_ff + LW'(1);
            left_in = left_ff - LW'(1);
            if (last_left) total_in = total_ff - count_ff;
         end
         ST_SPLIT: begin
            status_in = STATUS_OK;
         end
         ST_DONE: begin
            status_in = status_ff;
         end
         default: status_in = status_ff;
      endcase
   end

   // ----------------------------------------------------------------------
   // Response register
   // ----------------------------------------------------------------------
   logic          rsp_load;
   logic [WW-1:0] where_w;

   assign rsp_load     = (state_ff == ST_DONE) && rsp_slot_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign where_w      = WW'(where_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept || (state_ff != ST_IDLE)) begin
         op_ff       <= op_in;
         first_ff    <= first_in;
         count_ff    <= count_in;
         left_ff     <= left_in;
         acc_ff      <= acc_in;
         head_len_ff <= head_len_in;
         where_ff    <= where_in;
         status_ff   <= status_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_index_ff  <= ((status_ff == STATUS_OK) && (op_ff == OP_ALLOC)) ?
                          where_w[7:0] : 8'd0;
         rsp_count_ff  <= total_w[8:0];
      end
   end

   // page memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) page_mem_ff[mem_waddr] <= mem_wdata;
      rd_data_ff <= page_mem_ff[mem_raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_page_index_res = rsp_index_ff;
   assign rsp_free_count     = rsp_count_ff;

endmodule

>>> rtl/core/ffpa_checker.sv
// ----------------------------------------------------------------------------
// First-fit page allocator port checker
// Watches the top-level ports and flags protocol and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_checker
   import ffpa_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_page_index_res,
   input logic [8:0] rsp_free_count
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_page_index_res) && $stable(rsp_free_count))
      else $error("response changed while stalled");

   // page index only reported on success
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_page_index_res == 8'd0)
      else $error("page index set on a failed request");

   // one request in flight
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // clearing pass holds off requests, no stale response
   a_post_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall && !rsp_valid)
      else $error("block not quiet after reset");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_page_index_res (rsp_page_index_res),
   .rsp_free_count     (rsp_free_count)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// First-fit page allocator testbench
// Drives add, allocate and free requests with random idling on both channels
// and checks every response against a behavioural model of the page pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
   import ffpa_pkg::*;
();

   localparam int     PAGES        = 256;
   localparam int     RANDOM_ITEMS = 950;
   localparam int     LONG_HOLD    = 300;   // receiver hold-off, cycles
   localparam int     TAIL_CYCLES  = 1000;
   localparam longint CYCLE_LIMIT  = 2_000_000;
   localparam int     MAX_PRINTS   = 20;

   typedef struct {
      logic [1:0] op;
      logic [7:0] first;
      logic [8:0] count;
   } page_req_type;

   typedef struct {
      logic [1:0] status;
      logic [7:0] page;
      logic [8:0] free_count;
   } page_rsp_type;

   // maximal run of taken pages, used to build legal add and free ranges
   typedef struct {
      int first;
      int count;
   } page_run_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = OP_ADD;
   logic [7:0] req_page_index = '0;
   logic [8:0] req_page_count = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_page_index_res;
   logic [8:0] rsp_free_count;

   // page pool model: free bit per page, block length at each free head
   bit         page_free [PAGES];
   bit   [8:0] run_len [PAGES];
   bit   [8:0] pages_free;

   page_req_type req_backlog [$];   // requests waiting to be offered
   page_rsp_type rsp_due [$];       // predicted responses, oldest first
   page_run_type taken_runs [$];

   bit         calm = 1'b0;       // no idling on either side while set
   int         hold_asked = 0;
   int         holds_served = 0;
   int         stall_left = 0;
   int         idle_left = 0;
   int         mismatches = 0;
   int         rsp_count = 0;
   int         grants = 0;
   int         refusals = 0;
   int         rejects = 0;
   int         region_ops = 0;
   int         queued = 0;
   int         directed = 0;
   longint     cycles = 0;

   first_fit_page_allocator #(
      .PAGES(PAGES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_page_index(req_page_index),
      .req_page_count(req_page_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_page_index_res(rsp_page_index_res),
      .rsp_free_count(rsp_free_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Pool model. Updates the state for one accepted request and returns the
   // response the block must give for it.
   // -------------------------------------------------------------------------
   function automatic page_rsp_type serve_request(input logic [1:0] op,
                                                  input logic [7:0] first,
                                                  input logic [8:0] count);
      page_rsp_type r;
      int        top;
      int        h;
      bit        clash;
      bit  [8:0] len;
      r.status = STATUS_OK;
      r.page   = '0;
      top      = int'(first) + int'(count);
      if (count == 0 || op == OP_RSVD) begin
         r.status = STATUS_BAD;
      end else if (op == OP_ALLOC) begin
         r.status = STATUS_NOFIT;
         // a request above the free total is refused without a scan
         if (count <= pages_free) begin
            for (int p = 0; p < PAGES; p++) begin
               if (page_free[p] && run_len[p] >= count) begin
                  len = run_len[p];
                  for (int k = 0; k < count; k++) begin
                     page_free[p + k] = 1'b0;
                     run_len[p + k]   = '0;
                  end
                  // remainder becomes a new head just above the taken pages
                  if (len > count) run_len[p + count] = len - count;
                  pages_free = pages_free - count;
                  r.status   = STATUS_OK;
                  r.page     = p[7:0];
                  break;
               end
            end
         end
      end else begin
         // add and free need a range inside the pool with no page free yet
         clash = (top > PAGES);
         for (int p = first; p < top && !clash; p++) begin
            if (page_free[p]) clash = 1'b1;
         end
         if (clash) begin
            r.status = STATUS_BAD;
         end else begin
            for (int p = first; p < top; p++) begin
               page_free[p] = 1'b1;
               run_len[p]   = '0;
            end
            run_len[first] = count;
            pages_free     = pages_free + count;
            if (op == OP_FREE) begin
               // absorb a block starting right above
               if (top < PAGES && page_free[top] && run_len[top] != 0) begin
                  run_len[first] = run_len[first] + run_len[top];
                  run_len[top]   = '0;
               end
               // then fold into a block ending right below
               if (first > 0 && page_free[first - 1]) begin
                  h = first - 1;
                  while (run_len[h] == 0 && h > 0 && page_free[h - 1]) h--;
                  if (run_len[h] != 0) begin
                     run_len[h]     = run_len[h] + run_len[first];
                     run_len[first] = '0;
                  end
               end
            end
         end
      end
      r.free_count = pages_free;
      case (r.status)
         STATUS_OK:    if (op == OP_ALLOC) grants++; else region_ops++;
         STATUS_NOFIT: refusals++;
         default:      rejects++;
      endcase
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int alloc_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 8);
      if (roll < 92) return $urandom_range(9, 64);
      return $urandom_range(65, 256);
   endfunction

   function automatic void push_req(input logic [1:0] op, input logic [7:0] first,
                                    input logic [8:0] count);
      page_req_type item;
      item.op    = op;
      item.first = first;
      item.count = count;
      req_backlog.push_back(item);
      queued++;
   endfunction

   // Cut a random range out of one run of taken pages; the leftovers go back
   // so that later requests in the same batch stay legal.
   function automatic bit carve_taken_range(output int first, output int count);
      page_run_type run;
      page_run_type rest;
      int        slot;
      first = 0;
      count = 0;
      if (taken_runs.size() == 0) return 1'b0;
      slot = $urandom_range(0, taken_runs.size() - 1);
      run  = taken_runs[slot];
      taken_runs.delete(slot);
      case ($urandom_range(0, 9))
         0, 1:    count = run.count;
         2:       count = $urandom_range(1, run.count);
         default: count = $urandom_range(1, (run.count < 8) ? run.count : 8);
      endcase
      first = run.first + $urandom_range(0, run.count - count);
      if (first > run.first) begin
         rest.first = run.first;
         rest.count = first - run.first;
         taken_runs.push_back(rest);
      end
      if (run.first + run.count > first + count) begin
         rest.first = first + count;
         rest.count = run.first + run.count - (first + count);
         taken_runs.push_back(rest);
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t ns] ERROR: %s", $time, what);
   endtask

   // sender pauses until every transfer so far has been answered
   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Request driver. Predicts on every accepted transfer; a stalled payload
   // is held as it is. A gap, when drawn, follows the item just offered.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      page_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left <= 0;
      end else begin
         if (req_valid && !req_stall)
            rsp_due.push_back(serve_request(req_op, req_page_index, req_page_count));
         if (!(req_valid && req_stall)) begin
            if (idle_left != 0) begin
               req_valid <= 1'b0;
               idle_left <= idle_left - 1;
            end else if (req_backlog.size() != 0) begin
               next_req       = req_backlog.pop_front();
               req_valid      <= 1'b1;
               req_op         <= next_req.op;
               req_page_index <= next_req.first;
               req_page_count <= next_req.count;
               idle_left      <= calm ? 0 : idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response stall. Random short and long stalls, plus a long hold-off each
   // time the stimulus asks for one, so the block backs up into req_stall.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      int n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (holds_served != hold_asked) begin
         holds_served <= holds_served + 1;
         stall_left   <= LONG_HOLD - 1;
         rsp_stall    <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         n = idle_len();
         rsp_stall  <= (n != 0);
         stall_left <= (n != 0) ? n - 1 : 0;
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor: each transfer against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      page_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                      rsp_count));
         end else begin
            want = rsp_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                         rsp_count, rsp_status, want.status));
            if (rsp_page_index_res !== want.page)
               report_mismatch($sformatf("response %0d page %0d, expected %0d",
                                         rsp_count, rsp_page_index_res, want.page));
            if (rsp_free_count !== want.free_count)
               report_mismatch($sformatf("response %0d free count %0d, expected %0d",
                                         rsp_count, rsp_free_count, want.free_count));
         end
         rsp_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.",
                  cycles, rsp_due.size());
         $display("first_fit_page_allocator test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus. Directed cases first, then batches of random requests built
   // from the model state at the start of each batch: legal frees and adds
   // cut from runs of taken pages, allocations of mostly small sizes, and
   // some malformed noise.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int batch;
      int batch_len;
      int first;
      int count;
      int roll;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pool and malformed requests
      push_req(OP_ALLOC, 8'd0,   9'd1);     // above free total
      push_req(OP_ADD,   8'd0,   9'd0);     // zero count
      push_req(OP_RSVD,  8'd255, 9'd256);   // unknown op
      push_req(OP_ADD,   8'd255, 9'd2);     // runs past the pool
      push_req(OP_ADD,   8'd0,   9'd256);   // whole pool
      push_req(OP_ADD,   8'd10,  9'd1);     // already free
      push_req(OP_FREE,  8'd200, 9'd511);   // count field all ones
      push_req(OP_ALLOC, 8'd255, 9'd257);   // above free total
      push_req(OP_ALLOC, 8'd0,   9'd256);
      push_req(OP_FREE,  8'd0,   9'd256);
      // split, then free with no merge, a merge above and merges on both sides
      push_req(OP_ALLOC, 8'd0,   9'd100);
      push_req(OP_ALLOC, 8'd0,   9'd50);
      push_req(OP_ALLOC, 8'd0,   9'd6);
      push_req(OP_FREE,  8'd100, 9'd50);
      push_req(OP_FREE,  8'd0,   9'd100);
      push_req(OP_FREE,  8'd150, 9'd6);
      // fragmentation: enough pages in total but no block fits
      push_req(OP_ALLOC, 8'd0,   9'd256);
      push_req(OP_FREE,  8'd0,   9'd10);
      push_req(OP_FREE,  8'd20,  9'd10);
      push_req(OP_ALLOC, 8'd0,   9'd15);
      push_req(OP_ALLOC, 8'd0,   9'd10);
      push_req(OP_FREE,  8'd255, 9'd1);     // top page, nothing above
      push_req(OP_FREE,  8'd5,   9'd3);
      push_req(OP_ADD,   8'd30,  9'd200);   // no merge with the block below
      push_req(OP_FREE,  8'd250, 9'd5);
      directed = queued;
      wait_drained();

      batch = 0;
      while (queued < directed + RANDOM_ITEMS) begin
         batch++;
         taken_runs.delete();
         for (int p = 0; p < PAGES; p++) begin
            if (!page_free[p]) begin
               if (p > 0 && !page_free[p - 1])
                  taken_runs[taken_runs.size() - 1].count += 1;
               else
                  taken_runs.push_back('{p, 1});
            end
         end
         calm      = (batch % 6 == 3);
         batch_len = $urandom_range(1, 24);
         if (batch == 10 || batch == 40) begin
            // sender keeps offering through a long receiver hold-off
            batch_len = 24;
            calm      = 1'b0;
            hold_asked++;
         end
         for (int i = 0; i < batch_len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
               push_req(OP_ALLOC, 8'($urandom_range(0, 255)), 9'(alloc_size()));
            end else if (roll < 80 && carve_taken_range(first, count)) begin
               push_req((roll < 70) ? OP_FREE : OP_ADD, 8'(first), 9'(count));
            end else begin
               // noise: any op, any index, counts from zero to all ones
               case ($urandom_range(0, 3))
                  0:       count = 0;
                  1:       count = $urandom_range(0, 511);
                  default: count = $urandom_range(1, 16);
               endcase
               push_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        9'(count));
            end
         end
         wait_drained();
      end
      calm = 1'b0;

      repeat (TAIL_CYCLES) @(negedge clock);
      if (rsp_due.size() != 0)
         report_mismatch($sformatf("%0d predicted responses never arrived", rsp_due.size()));
      $display("Sent %0d requests (%0d directed) in %0d random batches: %0d allocations",
               queued, directed, batch, grants);
      $display("granted, %0d refused, %0d adds/frees taken, %0d rejected; %0d long holds.",
               refusals, region_ops, rejects, holds_served);
      if (mismatches == 0) begin
         $display("first_fit_page_allocator test passed");
      end else begin
         $display("first_fit_page_allocator test failed");
      end
      $finish;
   end

endmodule
